FILE: rtl/c_token_lexer_assert.svh
// Assertion macros used by the lexer checker.
`ifndef C_TOKEN_LEXER_ASSERT_SVH
`define C_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CLX_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CLX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/clx_pkg.sv
package clx_pkg;

	localparam int OFFSET_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
	localparam int MAX_TOKENS = 3;
	localparam int MAX_PASSES = 6;

	localparam logic [2:0] CL_WORD  = 3'd0;
	localparam logic [2:0] CL_DEC   = 3'd1;
	localparam logic [2:0] CL_OCT   = 3'd2;
	localparam logic [2:0] CL_HEX   = 3'd3;
	localparam logic [2:0] CL_FLOAT = 3'd4;
	localparam logic [2:0] CL_OP    = 3'd5;

	localparam logic [5:0] OP_LPAREN  = 6'd0;
	localparam logic [5:0] OP_RPAREN  = 6'd1;
	localparam logic [5:0] OP_LBRACK  = 6'd2;
	localparam logic [5:0] OP_RBRACK  = 6'd3;
	localparam logic [5:0] OP_DOT     = 6'd4;
	localparam logic [5:0] OP_ARROW   = 6'd5;
	localparam logic [5:0] OP_SIZEOF  = 6'd6;
	localparam logic [5:0] OP_COMMA   = 6'd7;
	localparam logic [5:0] OP_NOT     = 6'd8;
	localparam logic [5:0] OP_TILDE   = 6'd9;
	localparam logic [5:0] OP_SHR     = 6'd10;
	localparam logic [5:0] OP_SHL     = 6'd11;
	localparam logic [5:0] OP_XOR     = 6'd12;
	localparam logic [5:0] OP_OR      = 6'd13;
	localparam logic [5:0] OP_INC     = 6'd14;
	localparam logic [5:0] OP_DEC     = 6'd15;
	localparam logic [5:0] OP_PLUS    = 6'd16;
	localparam logic [5:0] OP_DIV     = 6'd17;
	localparam logic [5:0] OP_MOD     = 6'd18;
	localparam logic [5:0] OP_LOR     = 6'd19;
	localparam logic [5:0] OP_LAND    = 6'd20;
	localparam logic [5:0] OP_QUEST   = 6'd21;
	localparam logic [5:0] OP_COLON   = 6'd22;
	localparam logic [5:0] OP_EQ      = 6'd23;
	localparam logic [5:0] OP_NE      = 6'd24;
	localparam logic [5:0] OP_LT      = 6'd25;
	localparam logic [5:0] OP_GT      = 6'd26;
	localparam logic [5:0] OP_LE      = 6'd27;
	localparam logic [5:0] OP_GE      = 6'd28;
	localparam logic [5:0] OP_ASSIGN  = 6'd29;
	localparam logic [5:0] OP_ADD_EQ  = 6'd30;
	localparam logic [5:0] OP_SUB_EQ  = 6'd31;
	localparam logic [5:0] OP_MUL_EQ  = 6'd32;
	localparam logic [5:0] OP_DIV_EQ  = 6'd33;
	localparam logic [5:0] OP_MOD_EQ  = 6'd34;
	localparam logic [5:0] OP_SHR_EQ  = 6'd35;
	localparam logic [5:0] OP_SHL_EQ  = 6'd36;
	localparam logic [5:0] OP_AND_EQ  = 6'd37;
	localparam logic [5:0] OP_XOR_EQ  = 6'd38;
	localparam logic [5:0] OP_OR_EQ   = 6'd39;
	localparam logic [5:0] OP_AMP     = 6'd40;
	localparam logic [5:0] OP_MINUS   = 6'd41;
	localparam logic [5:0] OP_STAR    = 6'd42;
	localparam logic [5:0] OP_UNKNOWN = 6'd43;
	localparam logic [5:0] OP_NONE    = 6'd0;

	localparam logic [15:0] LENGTH_MAX = 16'hFFFF;
	localparam logic [2:0] SIZEOF_LEN = 3'd6;

	typedef enum logic [7:0] {
		M_IDLE     = 8'b0000_0001,
		M_WORD     = 8'b0000_0010,
		M_DEC      = 8'b0000_0100,
		M_OCT      = 8'b0000_1000,
		M_HEX      = 8'b0001_0000,
		M_FLOAT    = 8'b0010_0000,
		M_EXP_SIGN = 8'b0100_0000,
		M_EXP_DIG  = 8'b1000_0000
	} scan_mode_t;

	typedef struct packed {
		logic [2:0]  cls;
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0]     cnt;
		tok_t [2:0]     res;
	} bundle_t;

	typedef struct packed {
		scan_mode_t  mode;
		logic [15:0] start;
		logic [15:0] len;
		logic [7:0]  la0;
		logic [7:0]  la1;
		logic [1:0]  la_cnt;
		logic [2:0]  szm;
	} lex_state_t;

	typedef struct packed {
		lex_state_t st;
		bundle_t    b;
	} lex_out_t;

	// queue status toward the front and back ends
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic is_digit(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_space(logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_hex(logic [7:0] c);
		return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic logic [7:0] sizeof_char(logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = "s";
			3'd1: r = "i";
			3'd2: r = "z";
			3'd3: r = "e";
			3'd4: r = "o";
			default: r = "f";
		endcase
		return r;
	endfunction

	// Operator decode: returns {length, kind}; length 0 means more bytes needed.
	function automatic logic [7:0] op_decide(logic [7:0] c0, logic [7:0] c1,
			logic [7:0] c2, logic [1:0] have);
		logic [1:0] l;
		logic [5:0] k;
		l = 2'd1;
		k = OP_UNKNOWN;
		unique case (c0)
			"(": k = OP_LPAREN;
			")": k = OP_RPAREN;
			"[": k = OP_LBRACK;
			"]": k = OP_RBRACK;
			".": k = OP_DOT;
			",": k = OP_COMMA;
			"~": k = OP_TILDE;
			"?": k = OP_QUEST;
			":": k = OP_COLON;
			"+": begin
				if (c1 == "+") begin l = 2'd2; k = OP_INC; end
				else if (c1 == "=") begin l = 2'd2; k = OP_ADD_EQ; end
				else k = OP_PLUS;
			end
			"-": begin
				if (c1 == "-") begin l = 2'd2; k = OP_DEC; end
				else if (c1 == "=") begin l = 2'd2; k = OP_SUB_EQ; end
				else if (c1 == ">") begin l = 2'd2; k = OP_ARROW; end
				else k = OP_MINUS;
			end
			"!": begin
				if (c1 == "=") begin l = 2'd2; k = OP_NE; end
				else k = OP_NOT;
			end
			"^": begin
				if (c1 == "=") begin l = 2'd2; k = OP_XOR_EQ; end
				else k = OP_XOR;
			end
			"|": begin
				if (c1 == "|") begin l = 2'd2; k = OP_LOR; end
				else if (c1 == "=") begin l = 2'd2; k = OP_OR_EQ; end
				else k = OP_OR;
			end
			"/": begin
				if (c1 == "=") begin l = 2'd2; k = OP_DIV_EQ; end
				else k = OP_DIV;
			end
			"&": begin
				if (c1 == "&") begin l = 2'd2; k = OP_LAND; end
				else if (c1 == "=") begin l = 2'd2; k = OP_AND_EQ; end
				else k = OP_AMP;
			end
			"=": begin
				if (c1 == "=") begin l = 2'd2; k = OP_EQ; end
				else k = OP_ASSIGN;
			end
			"*": begin
				if (c1 == "=") begin l = 2'd2; k = OP_MUL_EQ; end
				else k = OP_STAR;
			end
			"%": begin
				if (c1 == "=") begin l = 2'd2; k = OP_MOD_EQ; end
				else k = OP_MOD;
			end
			"<": begin
				if (c1 == "<") begin
					if (have < 2'd3) l = 2'd0;
					else if (c2 == "=") begin l = 2'd3; k = OP_SHL_EQ; end
					else begin l = 2'd2; k = OP_SHL; end
				end else if (c1 == "=") begin l = 2'd2; k = OP_LE; end
				else k = OP_LT;
			end
			">": begin
				if (c1 == ">") begin
					if (have < 2'd3) l = 2'd0;
					else if (c2 == "=") begin l = 2'd3; k = OP_SHR_EQ; end
					else begin l = 2'd2; k = OP_SHR; end
				end else if (c1 == "=") begin l = 2'd2; k = OP_GE; end
				else k = OP_GT;
			end
			default: k = OP_UNKNOWN;
		endcase
		// two-byte leads wait for their second byte
		if (have < 2'd2 && k != OP_UNKNOWN && k != OP_LPAREN && k != OP_RPAREN &&
				k != OP_LBRACK && k != OP_RBRACK && k != OP_DOT && k != OP_COMMA &&
				k != OP_TILDE && k != OP_QUEST && k != OP_COLON)
			l = 2'd0;
		return {l, k};
	endfunction

	// One byte through the scanner: up to six decision passes over the held bytes.
	function automatic lex_out_t lex_step(lex_state_t s, logic [7:0] c, logic [15:0] pos);
		lex_out_t o;
		logic [7:0] q0, q1, q2, e1, e2;
		logic [1:0] n, used, have;
		logic [15:0] here;
		logic stop, stall, endt, cl;
		logic [2:0] ccls;
		logic [7:0] od;
		o.st = s;
		o.b = '0;
		endt = (c == 8'd0);
		q0 = s.la0;
		q1 = s.la1;
		q2 = 8'd0;
		case (s.la_cnt)
			2'd0: q0 = c;
			2'd1: q1 = c;
			default: q2 = c;
		endcase
		n = s.la_cnt + 2'd1;
		stop = 1'b0;
		for (int it = 0; it < MAX_PASSES; it++) begin
			if (!stop && n != 2'd0) begin
				e1 = (n > 2'd1) ? q1 : 8'd0;
				e2 = (n > 2'd2) ? q2 : 8'd0;
				have = endt ? 2'd3 : n;
				here = pos - {14'd0, n};
				used = 2'd0;
				stall = 1'b0;
				cl = 1'b0;
				ccls = CL_WORD;
				unique case (o.st.mode)
					M_WORD: begin
						if (is_digit(q0) || is_alpha(q0)) begin
							used = 2'd1;
							if (o.st.szm < SIZEOF_LEN && {13'd0, o.st.szm} == o.st.len &&
									q0 == sizeof_char(o.st.szm))
								o.st.szm = o.st.szm + 3'd1;
							else
								o.st.szm = 3'd0;
							if (o.st.len != LENGTH_MAX) o.st.len = o.st.len + 16'd1;
							if (o.st.szm == SIZEOF_LEN) begin
								if (o.b.cnt != 2'd3) begin
									o.b.res[o.b.cnt] = {CL_OP, OP_SIZEOF, o.st.start, 16'd6, 1'b0};
									o.b.cnt = o.b.cnt + 2'd1;
								end
								o.st.mode = M_IDLE;
								o.st.szm = 3'd0;
							end
						end else begin
							cl = 1'b1; ccls = CL_WORD;
						end
					end
					M_DEC: begin
						if (is_digit(q0)) used = 2'd1;
						else if (q0 == ".") begin
							if (have < 2'd2) stall = 1'b1;
							else if (is_digit(e1)) begin
								used = 2'd1; o.st.mode = M_FLOAT;
							end else begin
								cl = 1'b1; ccls = CL_DEC;
							end
						end else begin
							cl = 1'b1; ccls = CL_DEC;
						end
					end
					M_OCT: begin
						if (q0 >= "0" && q0 <= "7") used = 2'd1;
						else if (q0 == "8" || q0 == "9") begin
							used = 2'd1; o.st.mode = M_DEC;
						end else if (q0 == ".") begin
							used = 2'd1; o.st.mode = M_FLOAT;
						end else begin
							cl = 1'b1; ccls = CL_OCT;
						end
					end
					M_HEX: begin
						if (is_hex(q0)) used = 2'd1;
						else begin cl = 1'b1; ccls = CL_HEX; end
					end
					M_FLOAT: begin
						if (is_digit(q0)) used = 2'd1;
						else if (q0 == "e" || q0 == "E") begin
							if (have < 2'd2) stall = 1'b1;
							else if (e1 == "+" || e1 == "-" || is_digit(e1)) begin
								used = 2'd1; o.st.mode = M_EXP_SIGN;
							end else begin
								cl = 1'b1; ccls = CL_FLOAT;
							end
						end else begin
							cl = 1'b1; ccls = CL_FLOAT;
						end
					end
					M_EXP_SIGN: begin
						if (q0 == "+" || q0 == "-" || is_digit(q0)) begin
							used = 2'd1; o.st.mode = M_EXP_DIG;
						end else begin
							cl = 1'b1; ccls = CL_FLOAT;
						end
					end
					M_EXP_DIG: begin
						if (is_digit(q0)) used = 2'd1;
						else begin cl = 1'b1; ccls = CL_FLOAT; end
					end
					default: begin
						o.st.mode = M_IDLE;
						o.st.szm = 3'd0;
						if (q0 == 8'd0 || is_space(q0)) used = 2'd1;
						else if (is_alpha(q0)) begin
							used = 2'd1;
							o.st.mode = M_WORD; o.st.start = here; o.st.len = 16'd1;
							o.st.szm = (q0 == "s") ? 3'd1 : 3'd0;
						end else if (q0 == "0") begin
							if (have < 2'd2) stall = 1'b1;
							else if (e1 == "x" || e1 == "X") begin
								used = 2'd2;
								o.st.mode = M_HEX; o.st.start = here; o.st.len = 16'd2;
							end else begin
								used = 2'd1;
								o.st.mode = M_OCT; o.st.start = here; o.st.len = 16'd1;
							end
						end else if (is_digit(q0)) begin
							used = 2'd1;
							o.st.mode = M_DEC; o.st.start = here; o.st.len = 16'd1;
						end else begin
							od = op_decide(q0, e1, e2, have);
							if (od[7:6] == 2'd0) stall = 1'b1;
							else begin
								if (o.b.cnt != 2'd3) begin
									o.b.res[o.b.cnt] = {CL_OP, od[5:0], here, 14'd0, od[7:6], 1'b0};
									o.b.cnt = o.b.cnt + 2'd1;
								end
								used = od[7:6];
							end
						end
					end
				endcase
				// number modes grow the token by the byte they took
				if (used != 2'd0 && s.mode != M_IDLE && s.mode != M_WORD &&
						o.st.len != LENGTH_MAX)
					o.st.len = o.st.len + 16'd1;
				if (cl) begin
					if (o.b.cnt != 2'd3) begin
						o.b.res[o.b.cnt] = {ccls, OP_NONE, o.st.start, o.st.len, 1'b0};
						o.b.cnt = o.b.cnt + 2'd1;
					end
					o.st.mode = M_IDLE;
					o.st.szm = 3'd0;
				end
				if (stall) stop = 1'b1;
				else begin
					if (used > n) used = n;
					if (used == 2'd1) begin q0 = q1; q1 = q2; end
					else if (used == 2'd2) q0 = q2;
					n = n - used;
				end
			end
			s = o.st;
		end
		if (endt) begin
			o.st = '{mode: M_IDLE, default: '0};
		end else begin
			o.st.la0 = q0;
			o.st.la1 = q1;
			o.st.la_cnt = (n > 2'd2) ? 2'd2 : n;
		end
		if (o.b.cnt != 2'd0) o.b.res[o.b.cnt - 2'd1].last = 1'b1;
		return o;
	endfunction

endpackage

FILE: rtl/clx_front.sv
module clx_front #(
	parameter int OFFSET_WIDTH = clx_pkg::OFFSET_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_char,
	input  clx_pkg::q_status_t q_stat,
	output logic               push,
	output clx_pkg::bundle_t   push_data
);

	localparam logic [15:0] START_MASK = (OFFSET_WIDTH >= 16) ? 16'hFFFF :
		16'((32'd1 << OFFSET_WIDTH) - 32'd1);

	clx_pkg::lex_state_t st_q;
	logic [OFFSET_WIDTH-1:0] pos_q;
	logic [OFFSET_WIDTH-1:0] pos_inc;
	clx_pkg::lex_out_t nx;
	logic take;

	assign in_ready = !q_stat.full;
	assign take = in_valid && in_ready;
	assign pos_inc = pos_q + OFFSET_WIDTH'(1);
	assign nx = clx_pkg::lex_step(st_q, in_char, 16'(pos_inc));

	always_comb begin
		push_data = nx.b;
		for (int i = 0; i < clx_pkg::MAX_TOKENS; i++)
			push_data.res[i].start = nx.b.res[i].start & START_MASK;
	end
	assign push = take && (nx.b.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{mode: clx_pkg::M_IDLE, default: '0};
			pos_q <= '0;
		end else if (take) begin
			st_q <= nx.st;
			pos_q <= (in_char == 8'd0) ? '0 : pos_inc;
		end
	end

endmodule

FILE: rtl/clx_queue.sv
module clx_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  clx_pkg::bundle_t   push_data,
	input  logic               pop,
	output clx_pkg::bundle_t   head,
	output clx_pkg::q_status_t stat
);

	localparam int AW = clx_pkg::QUEUE_AW;

	clx_pkg::bundle_t mem_q [clx_pkg::QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0] cnt_q;

	assign stat.full = (cnt_q == (AW+1)'(clx_pkg::QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + AW'(1);
			if (pop) rd_q <= rd_q + AW'(1);
			if (push && !pop) cnt_q <= cnt_q + (AW+1)'(1);
			else if (pop && !push) cnt_q <= cnt_q - (AW+1)'(1);
		end
	end

endmodule

FILE: rtl/clx_back.sv
module clx_back (
	input  logic               clk,
	input  logic               arst_n,
	input  clx_pkg::bundle_t   head,
	input  clx_pkg::q_status_t q_stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output clx_pkg::tok_t      out_tok
);

	logic [1:0] idx_q;
	logic fire;

	assign out_valid = !q_stat.empty;
	assign out_tok = head.res[idx_q];
	assign fire = out_valid && out_ready;
	assign pop = fire && (idx_q == head.cnt - 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (fire) begin
			idx_q <= pop ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

FILE: rtl/c_token_lexer.sv
// C source tokenizer. Bytes of text arrive on the s_axis side, one per
// transfer, and byte 0 ends the text: it flushes every pending token and
// sets the offset back to zero. White space is skipped; every token comes
// out on the m_axis side as {class, operator kind, start offset, length},
// with tlast on the last token a byte caused. A byte that causes no token
// gives no transfer. The front end takes one byte every cycle unless the
// queue is full and decodes it in that cycle; its tokens (up to three) go as
// one entry into a four-entry queue, and the back end sends one token per
// cycle from the queue head while the sink is ready. Sustained rate is one
// byte per cycle as long as the bytes average at most one token each; it is
// set by the single token port. OFFSET_WIDTH sets the offset counter; start
// offsets wrap at 2^OFFSET_WIDTH, lengths saturate at 65535.
module c_token_lexer #(
	parameter int OFFSET_WIDTH = clx_pkg::OFFSET_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [2:0] token_class, [8:3] operator_kind,
	                                    // [24:9] token_start, [40:25] token_length,
	                                    // [47:41] zero
	output logic        m_axis_tlast    // last_of_run
);

	clx_pkg::q_status_t q_stat;
	clx_pkg::bundle_t push_data, head;
	clx_pkg::tok_t tok;
	logic push, pop;

	clx_front #(.OFFSET_WIDTH(OFFSET_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_char(s_axis_tdata),
		.q_stat(q_stat), .push(push), .push_data(push_data)
	);

	clx_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .pop(pop),
		.head(head), .stat(q_stat)
	);

	clx_back u_back (
		.clk(clk), .arst_n(arst_n),
		.head(head), .q_stat(q_stat), .pop(pop),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_tok(tok)
	);

	assign m_axis_tdata = {7'd0, tok.len, tok.start, tok.kind, tok.cls};
	assign m_axis_tlast = tok.last;

endmodule

FILE: rtl/clx_check.sv
`include "c_token_lexer_assert.svh"

module clx_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata
);

	`CLX_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`CLX_ASSERT_IMPLY(a_len, m_axis_tvalid, m_axis_tdata[40:25] != 16'd0)
	`CLX_ASSERT_IMPLY(a_kind, m_axis_tvalid && m_axis_tdata[2:0] != clx_pkg::CL_OP, m_axis_tdata[8:3] == clx_pkg::OP_NONE)
	`CLX_ASSERT_IMPLY(a_sizeof, m_axis_tvalid && m_axis_tdata[2:0] == clx_pkg::CL_OP && m_axis_tdata[8:3] == clx_pkg::OP_SIZEOF, m_axis_tdata[40:25] == 16'd6)

endmodule

bind c_token_lexer clx_check u_check (
	.clk(clk), .arst_n(arst_n),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);

FILE: test/c_token_lexer_checker.sv
`timescale 1ns / 100ps

module c_token_lexer_checker
	import clx_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          fail_count,
	output int          tokens_pending
);

	typedef enum logic [2:0] {
		SC_IDLE, SC_WORD, SC_DEC, SC_OCT, SC_HEX, SC_FLOAT, SC_EXP_SIGN, SC_EXP_DIG
	} scan_t;

	typedef struct packed {
		logic [2:0]  cls;
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] len;
		logic        last;
	} token_t;

	token_t      token_q[$];
	scan_t       mode;
	logic [15:0] tok_start, tok_len, text_pos;
	logic [7:0]  held[2];
	int          held_cnt;
	int          sz_match;

	assign tokens_pending = token_q.size();

	function automatic bit dig(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit hexd(logic [7:0] c);
		return dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	// operator length 1..3 (0 = needs more bytes) and kind
	function automatic int oper_len(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2,
			int have, output logic [5:0] k);
		k = OP_UNKNOWN;
		case (c0)
			"(": begin k = OP_LPAREN; return 1; end
			")": begin k = OP_RPAREN; return 1; end
			"[": begin k = OP_LBRACK; return 1; end
			"]": begin k = OP_RBRACK; return 1; end
			".": begin k = OP_DOT; return 1; end
			",": begin k = OP_COMMA; return 1; end
			"~": begin k = OP_TILDE; return 1; end
			"?": begin k = OP_QUEST; return 1; end
			":": begin k = OP_COLON; return 1; end
			"+", "-", "!", "^", "|", "/", "&", "=", "*", "%", "<", ">": ;
			default: return 1;
		endcase
		if (have < 2) return 0;
		case (c0)
			"+": begin
				if (c1 == "+") begin k = OP_INC; return 2; end
				if (c1 == "=") begin k = OP_ADD_EQ; return 2; end
				k = OP_PLUS;
			end
			"-": begin
				if (c1 == "-") begin k = OP_DEC; return 2; end
				if (c1 == "=") begin k = OP_SUB_EQ; return 2; end
				if (c1 == ">") begin k = OP_ARROW; return 2; end
				k = OP_MINUS;
			end
			"!": begin
				if (c1 == "=") begin k = OP_NE; return 2; end
				k = OP_NOT;
			end
			"^": begin
				if (c1 == "=") begin k = OP_XOR_EQ; return 2; end
				k = OP_XOR;
			end
			"|": begin
				if (c1 == "|") begin k = OP_LOR; return 2; end
				if (c1 == "=") begin k = OP_OR_EQ; return 2; end
				k = OP_OR;
			end
			"/": begin
				if (c1 == "=") begin k = OP_DIV_EQ; return 2; end
				k = OP_DIV;
			end
			"&": begin
				if (c1 == "&") begin k = OP_LAND; return 2; end
				if (c1 == "=") begin k = OP_AND_EQ; return 2; end
				k = OP_AMP;
			end
			"=": begin
				if (c1 == "=") begin k = OP_EQ; return 2; end
				k = OP_ASSIGN;
			end
			"*": begin
				if (c1 == "=") begin k = OP_MUL_EQ; return 2; end
				k = OP_STAR;
			end
			"%": begin
				if (c1 == "=") begin k = OP_MOD_EQ; return 2; end
				k = OP_MOD;
			end
			"<": begin
				if (c1 == "<") begin
					if (have < 3) return 0;
					if (c2 == "=") begin k = OP_SHL_EQ; return 3; end
					k = OP_SHL; return 2;
				end
				if (c1 == "=") begin k = OP_LE; return 2; end
				k = OP_LT;
			end
			default: begin
				if (c1 == ">") begin
					if (have < 3) return 0;
					if (c2 == "=") begin k = OP_SHR_EQ; return 3; end
					k = OP_SHR; return 2;
				end
				if (c1 == "=") begin k = OP_GE; return 2; end
				k = OP_GT;
			end
		endcase
		return 1;
	endfunction

	function automatic void grow();
		if (tok_len != 16'hFFFF) tok_len++;
	endfunction

	// scan one byte, push the tokens it decides
	task automatic lex_byte(logic [7:0] c);
		logic [7:0] q[3];
		logic [7:0] c1, c2;
		logic [5:0] k;
		logic [15:0] here;
		token_t out[$];
		token_t t;
		int n, have, used, len;
		bit stall, fin, endt;
		scan_t cls_mode;
		endt = (c == 8'd0);
		for (int i = 0; i < held_cnt; i++) q[i] = held[i];
		q[held_cnt] = c;
		n = held_cnt + 1;
		text_pos++;
		while (n > 0) begin
			c1 = n > 1 ? q[1] : 8'd0;
			c2 = n > 2 ? q[2] : 8'd0;
			have = endt ? 3 : n;
			here = text_pos - 16'(n);
			used = 0; stall = 0; fin = 0; cls_mode = mode;
			case (mode)
				SC_WORD:
					if (dig(q[0]) || alpha(q[0])) begin
						used = 1;
						if (sz_match < 6 && sz_match == tok_len &&
								q[0] == sizeof_char(3'(sz_match)))
							sz_match++;
						else sz_match = 0;
						grow();
						if (sz_match == 6) begin
							out.push_back('{CL_OP, OP_SIZEOF, tok_start, 16'd6, 1'b0});
							mode = SC_IDLE; sz_match = 0;
						end
					end else fin = 1;
				SC_DEC:
					if (dig(q[0])) begin used = 1; grow(); end
					else if (q[0] == ".") begin
						if (have < 2) stall = 1;
						else if (dig(c1)) begin used = 1; grow(); mode = SC_FLOAT; end
						else fin = 1;
					end else fin = 1;
				SC_OCT:
					if (q[0] >= "0" && q[0] <= "7") begin used = 1; grow(); end
					else if (q[0] == "8" || q[0] == "9") begin
						used = 1; grow(); mode = SC_DEC;
					end else if (q[0] == ".") begin
						used = 1; grow(); mode = SC_FLOAT;
					end else fin = 1;
				SC_HEX:
					if (hexd(q[0])) begin used = 1; grow(); end
					else fin = 1;
				SC_FLOAT:
					if (dig(q[0])) begin used = 1; grow(); end
					else if (q[0] == "e" || q[0] == "E") begin
						if (have < 2) stall = 1;
						else if (c1 == "+" || c1 == "-" || dig(c1)) begin
							used = 1; grow(); mode = SC_EXP_SIGN;
						end else fin = 1;
					end else fin = 1;
				SC_EXP_SIGN:
					if (q[0] == "+" || q[0] == "-" || dig(q[0])) begin
						used = 1; grow(); mode = SC_EXP_DIG;
					end else fin = 1;
				SC_EXP_DIG:
					if (dig(q[0])) begin used = 1; grow(); end
					else fin = 1;
				default: begin
					sz_match = 0;
					if (q[0] == 8'd0 || q[0] == " " || (q[0] >= 8'd9 && q[0] <= 8'd13))
						used = 1;
					else if (alpha(q[0])) begin
						used = 1; mode = SC_WORD; tok_start = here; tok_len = 1;
						sz_match = (q[0] == "s") ? 1 : 0;
					end else if (q[0] == "0") begin
						if (have < 2) stall = 1;
						else if (c1 == "x" || c1 == "X") begin
							used = 2; mode = SC_HEX; tok_start = here; tok_len = 2;
						end else begin
							used = 1; mode = SC_OCT; tok_start = here; tok_len = 1;
						end
					end else if (dig(q[0])) begin
						used = 1; mode = SC_DEC; tok_start = here; tok_len = 1;
					end else begin
						len = oper_len(q[0], c1, c2, have, k);
						if (len == 0) stall = 1;
						else begin
							out.push_back('{CL_OP, k, here, 16'(len), 1'b0});
							used = len;
						end
					end
				end
			endcase
			if (fin) begin
				case (cls_mode)
					SC_WORD: t.cls = CL_WORD;
					SC_DEC: t.cls = CL_DEC;
					SC_OCT: t.cls = CL_OCT;
					SC_HEX: t.cls = CL_HEX;
					default: t.cls = CL_FLOAT;
				endcase
				t.kind = OP_NONE; t.start = tok_start; t.len = tok_len; t.last = 0;
				out.push_back(t);
				mode = SC_IDLE; sz_match = 0;
			end
			if (stall) break;
			if (used > n) used = n;
			for (int i = used; i < n; i++) q[i - used] = q[i];
			n -= used;
		end
		if (endt) begin
			mode = SC_IDLE; tok_start = 0; tok_len = 0; held_cnt = 0;
			sz_match = 0; text_pos = 0;
		end else begin
			held_cnt = n > 2 ? 2 : n;
			for (int i = 0; i < held_cnt; i++) held[i] = q[i];
		end
		if (out.size() > 0) out[out.size() - 1].last = 1'b1;
		foreach (out[i]) token_q.push_back(out[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_t got, want;
		if (!arst_n) begin
			token_q.delete();
			mode = SC_IDLE; tok_start = 0; tok_len = 0; text_pos = 0;
			held_cnt = 0; sz_match = 0; fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = {m_axis_tdata[2:0], m_axis_tdata[8:3], m_axis_tdata[24:9],
					m_axis_tdata[40:25], m_axis_tlast};
				if (token_q.size() == 0) begin
					$display("%0t: unexpected token, actual %h", $time, got);
					fail_count++;
				end else begin
					want = token_q.pop_front();
					if (got != want || m_axis_tdata[47:41] != 0) begin
						$display("%0t: token mismatch, expected cls %0d kind %0d start %0d len %0d last %0b, actual cls %0d kind %0d start %0d len %0d last %0b tdata %h",
							$time, want.cls, want.kind, want.start, want.len, want.last,
							got.cls, got.kind, got.start, got.len, got.last, m_axis_tdata);
						fail_count++;
					end
				end
			end
			// queue after the compare so a same-cycle token is never checked early
			if (s_axis_tvalid && s_axis_tready)
				lex_byte(s_axis_tdata);
		end
	end

endmodule

FILE: test/c_token_lexer_test.sv
`timescale 1ns / 100ps

// Byte-stream test of the C tokenizer. A directed text covers every operator,
// each number form, sizeof, underscore, unlisted bytes and the flush on byte 0;
// then random texts built from C-like fragments plus raw noise bytes. The
// checker beside the block predicts every token and compares each transfer.
module c_token_lexer_test;
	import clx_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_count;
	int          tokens_pending;

	logic [7:0]  text_q[$];   // bytes still to send
	bit          quiet;       // last part of the run: no idling
	bit          hold_sink;   // long receiver hold-off request
	int          idle_cnt;
	bit          done_send;

	c_token_lexer DUT (.*);

	c_token_lexer_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic void add_str(string s);
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
	endfunction

	// random C-like fragment; noise is a small share
	function automatic void add_fragment();
		string frag[] = '{"sizeof", "sizeofx", "size", "_a", "0x1F", "0X", "0x", "017",
			"0189", "08.5", "0.", "12.5e+3", "1.5e+", "3.4E-1x", "1.2.3", "9e5", "5.",
			"1.5Ez", "<<=", ">>=", "<<", ">>", "<=", ">=", "->", "++", "--", "+=",
			"-=", "*=", "/=", "%=", "&=", "^=", "|=", "&&", "||", "==", "!=", "(",
			")", "[", "]", ".", ",", "~", "?", ":", "!", "^", "|", "/", "&", "=",
			"*", "%", "+", "-", "<", ">", "abc9", "Zeta", "x", " ", "\t", "\n", ";",
			"{", "#", "\"", "ssizeof", "sizeo", "42", "7"};
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) text_q.push_back(8'($urandom_range(1, 255)));
		else if (r < 12) text_q.push_back(8'($urandom_range(128, 255)));
		else add_str(frag[$urandom_range(0, frag.size() - 1)]);
		if ($urandom_range(0, 2) == 0) text_q.push_back(" ");
	endfunction

	// sender: random idle bursts, one nonblocking write per signal per edge
	initial begin
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		done_send = 0;
		quiet = 0;
		hold_sink = 0;
		arst_n = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		// directed text: operators, numbers, sizeof, underscore, flush
		add_str("(a)[b].c->d,!~>>1<<2^|++--+/%||&&?:==!=<>");
		text_q.push_back(8'd0);
		add_str("<=>=x=+=-=*=/=%=>>=<<=&=^=|=&-*");
		text_q.push_back(8'd0);
		add_str("sizeof sizeofab sizex_y 0x 0x1aF 0Xg 017 0189 0.5 08. 12.5e+3 ");
		add_str("1.5e+; 1.2.3 5.x 3e7 1.5Eq \t\n\v\f\r");
		text_q.push_back(8'd255);
		text_q.push_back(8'd128);
		text_q.push_back(8'd1);
		text_q.push_back(8'd0);
		add_str("<<");
		text_q.push_back(8'd0);
		add_str("1.");
		text_q.push_back(8'd0);
		while (text_q.size() < 220) begin
			add_fragment();
			if ($urandom_range(0, 19) == 0) text_q.push_back(8'd0);
		end
		add_str(" 1");
		text_q.push_back(8'd0);
		while (text_q.size() > 0) begin
			if (text_q.size() < 40) quiet = 1;
			if (text_q.size() == 150) hold_sink = 1;
			if (!quiet && $urandom_range(0, 7) == 0) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			s_axis_tvalid <= 1;
			s_axis_tdata <= text_q[0];
			@(posedge clk);
			while (!s_axis_tready) @(posedge clk);
			void'(text_q.pop_front());
		end
		s_axis_tvalid <= 0;
		done_send = 1;
	end

	// receiver: random stall bursts plus one long hold-off
	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				hold_sink = 0;
				m_axis_tready <= 0;
				repeat (60) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				m_axis_tready <= 1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	initial begin
		idle_cnt = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cnt = 0;
			else idle_cnt++;
			if (idle_cnt >= 2000) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		@(posedge arst_n);
		wait (done_send);
		while (tokens_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && tokens_pending == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

endmodule
